// ===== design/tmspc_pkg.sv =====
// Package for the tilemap and sprite pixel compositor.
// Holds opcodes, sequencer states, the sprite list entry and fixed address constants.
// No dependencies.
package tmspc_pkg;

   typedef enum logic [2:0] {
      OP_MEM_WRITE   = 3'd0,
      OP_TILE_GFX    = 3'd1,
      OP_SPRITE_GFX  = 3'd2,
      OP_PALETTE     = 3'd3,
      OP_START_FRAME = 3'd4,
      OP_QUERY       = 3'd5
   } op_type;

   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_CODE,
      ST_COLOR,
      ST_TGFX,
      ST_TPAL,
      ST_SPR,
      ST_OUT
   } state_type;

   typedef struct packed {
      logic signed [9:0] x;
      logic signed [9:0] y;
      logic [5:0]        code;
      logic [5:0]        color;
      logic [1:0]        flip;
   } sprite_entry_type;

   localparam logic [9:0]  TILE_TOP_BASE    = 10'h3DD;
   localparam logic [9:0]  TILE_BOTTOM_BASE = 10'h01D;
   localparam logic [9:0]  TILE_MID_BASE    = 10'h3A0;
   localparam logic [12:0] SPR_ATTR_BASE    = 13'h0FF0;
   localparam logic [12:0] SPR_POS_BASE     = 13'h1060;
   localparam logic [5:0]  ROW_BOTTOM       = 6'd34;
   localparam logic [5:0]  ROW_MID          = 6'd2;
   localparam logic signed [9:0] SPR_X_ORIGIN = 10'sd239;
   localparam logic signed [9:0] SPR_Y_ORIGIN = 10'sd272;
   localparam logic signed [9:0] SPR_MIN_POS  = -10'sd16;

endpackage

// ===== design/tilemap_sprite_pixel_compositor.sv =====
// Top level of the tilemap and sprite pixel compositor: sequencer and datapath.
// Depends on tmspc_pkg, tmspc_ram and tmspc_sprite_list.
//
//   Channel | Direction | Ports                                   | Beat
//   req     | in        | opcode, address, data, pixel_x, pixel_y | one operation
//   rsp     | out       | pixel_color                             | one query answer
//
// Load and start-frame beats complete as they are taken. An on-screen pixel
// query reads the tile code, tile color, tile graphics and tile palette in
// turn, then issues one listed sprite a cycle through the single sprite
// graphics read port and drains the last sprite hits through the graphics and
// palette reads. An off-screen query offers its answer the next cycle.
// After reset the video RAM is swept to zero, one entry a cycle, over all 2048
// entries, with req_stall held high. One query is in flight at a time; req_stall
// stays high until its answer beat is taken while rsp_stall is low.
module tilemap_sprite_pixel_compositor
   import tmspc_pkg::*;
#(
   parameter int SCREEN_WIDTH  = 224,
   parameter int SCREEN_HEIGHT = 288,
   parameter int SPRITE_SLOTS  = 8
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [2:0]  req_opcode,
   input  logic [12:0] req_address,
   input  logic [31:0] req_data,
   input  logic [7:0]  req_pixel_x,
   input  logic [8:0]  req_pixel_y,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [15:0] rsp_pixel_color
);

   localparam int CNT_W = $clog2(SPRITE_SLOTS + 1);
   localparam int IDX_W = (SPRITE_SLOTS > 1) ? $clog2(SPRITE_SLOTS) : 1;
   localparam logic [8:0] SW = 9'(SCREEN_WIDTH);
   localparam logic [9:0] SH = 10'(SCREEN_HEIGHT);

   state_type        state_ff, state_in;
   logic [10:0]      clr_idx_ff, clr_idx_in;
   logic [7:0]       px_ff, px_in;
   logic [8:0]       py_ff, py_in;
   logic [9:0]       taddr_ff, taddr_in;
   logic [7:0]       tcode_ff, tcode_in;
   logic [5:0]       tcol_ff, tcol_in;
   logic [1:0]       tpix_ff, tpix_in;
   logic [15:0]      color_ff, color_in;
   logic [CNT_W-1:0] issue_ff, issue_in;
   logic             v1_ff, v1_in;
   logic [3:0]       dx1_ff, dx1_in;
   logic [5:0]       col1_ff, col1_in;
   logic             v2_ff, v2_in;

   logic        accept;
   op_type      op;
   logic [9:0]  req_taddr;
   logic [5:0]  row;
   logic [4:0]  col;

   logic        vram_we;
   logic [10:0] vram_waddr, vram_raddr;
   logic [7:0]  vram_wdata, vram_rdata;
   logic        tgfx_we;
   logic [10:0] tgfx_raddr;
   logic [15:0] tgfx_rdata;
   logic        sgfx_we;
   logic [11:0] sgfx_raddr;
   logic [31:0] sgfx_rdata;
   logic        pal_we;
   logic [7:0]  pal_raddr;
   logic [15:0] pal_rdata;

   logic             spr_we;
   logic [4:0]       spr_idx;
   logic             latch;
   sprite_entry_type entry;
   logic [CNT_W-1:0] spr_count;

   logic signed [10:0] dx, dy;
   logic               issuing;
   logic [1:0]         sp;

   assign op        = op_type'(req_opcode);
   assign req_stall = (state_ff != ST_IDLE);
   assign accept    = req_valid && !req_stall;

   // Rotated screen: three regions map a tile row and column to its address.
   assign row = req_pixel_y[8:3];
   assign col = req_pixel_x[7:3];
   always_comb begin
      priority if (row < ROW_MID) begin
         req_taddr = TILE_TOP_BASE - 10'(col) + {row[4:0], 5'b0};
      end else if (row >= ROW_BOTTOM) begin
         req_taddr = TILE_BOTTOM_BASE - 10'(col) + {5'(row - ROW_BOTTOM), 5'b0};
      end else begin
         req_taddr = TILE_MID_BASE + 10'(row - ROW_MID) - {col, 5'b0};
      end
   end

   // Memory write ports: only loads in the idle state, or the clearing sweep.
   always_comb begin
      vram_we    = 1'b0;
      vram_waddr = req_address[10:0];
      vram_wdata = req_data[7:0];
      spr_we     = 1'b0;
      spr_idx    = {1'b0, req_address[3:0]};
      tgfx_we    = 1'b0;
      sgfx_we    = 1'b0;
      pal_we     = 1'b0;
      latch      = 1'b0;
      if (state_ff == ST_CLEAR) begin
         vram_we    = 1'b1;
         vram_waddr = clr_idx_ff;
         vram_wdata = '0;
      end else if (accept) begin
         unique case (op)
            OP_MEM_WRITE: begin
               if (req_address[12:11] == 2'b00) begin
                  vram_we = 1'b1;
               end else if (req_address[12:4] == SPR_ATTR_BASE[12:4]) begin
                  spr_we = 1'b1;
               end else if (req_address[12:4] == SPR_POS_BASE[12:4]) begin
                  spr_we  = 1'b1;
                  spr_idx = {1'b1, req_address[3:0]};
               end
            end
            OP_TILE_GFX:    tgfx_we = (req_address[12:11] == 2'b00);
            OP_SPRITE_GFX:  sgfx_we = !req_address[12];
            OP_PALETTE:     pal_we  = (req_address[12:8] == 5'd0);
            OP_START_FRAME: latch   = 1'b1;
            OP_QUERY:       ;
            default:        ;
         endcase
      end
   end

   // Sprite issue stage: position test against the current list entry.
   assign issuing = (issue_ff < spr_count);
   assign dx = signed'({3'b000, px_ff}) - 11'(entry.x);
   assign dy = signed'({2'b00, py_ff}) - 11'(entry.y);
   assign sp = 2'(sgfx_rdata >> {dx1_ff, 1'b0});

   always_comb begin
      state_in   = state_ff;
      clr_idx_in = clr_idx_ff;
      px_in      = px_ff;
      py_in      = py_ff;
      taddr_in   = taddr_ff;
      tcode_in   = tcode_ff;
      tcol_in    = tcol_ff;
      tpix_in    = tpix_ff;
      color_in   = color_ff;
      issue_in   = issue_ff;
      v1_in      = 1'b0;
      dx1_in     = dx1_ff;
      col1_in    = col1_ff;
      v2_in      = 1'b0;
      vram_raddr = {1'b1, taddr_ff};
      tgfx_raddr = {tcode_ff, py_ff[2:0]};
      sgfx_raddr = {entry.flip, entry.code, dy[3:0]};
      pal_raddr  = {col1_ff, sp};
      rsp_valid  = 1'b0;
      unique case (state_ff)
         ST_CLEAR: begin
            clr_idx_in = clr_idx_ff + 1'b1;
            if (clr_idx_ff == '1) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            vram_raddr = {1'b0, req_taddr};
            px_in      = req_pixel_x;
            py_in      = req_pixel_y;
            taddr_in   = req_taddr;
            if (accept && op == OP_QUERY) begin
               if ({1'b0, req_pixel_x} < SW && {1'b0, req_pixel_y} < SH) begin
                  state_in = ST_CODE;
               end else begin
                  color_in = '0;
                  state_in = ST_OUT;
               end
            end
         end
         ST_CODE: begin
            tcode_in = vram_rdata;
            state_in = ST_COLOR;
         end
         ST_COLOR: begin
            tcol_in  = vram_rdata[5:0];
            state_in = ST_TGFX;
         end
         ST_TGFX: begin
            tpix_in   = 2'(tgfx_rdata >> {px_ff[2:0], 1'b0});
            pal_raddr = {tcol_ff, tpix_in};
            state_in  = ST_TPAL;
         end
         ST_TPAL: begin
            color_in = (tpix_ff != 2'd0) ? pal_rdata : 16'd0;
            issue_in = '0;
            state_in = ST_SPR;
         end
         ST_SPR: begin
            // Three-deep pipeline: issue graphics read, palette read, apply.
            if (issuing) begin
               issue_in = issue_ff + 1'b1;
               v1_in    = (dx[10:4] == 7'd0) && (dy[10:4] == 7'd0);
               dx1_in   = dx[3:0];
               col1_in  = entry.color;
            end
            v2_in = v1_ff && (sp != 2'd0);
            if (v2_ff && pal_rdata != 16'd0) begin
               color_in = pal_rdata;
            end
            if (!issuing && !v1_ff && !v2_ff) begin
               state_in = ST_OUT;
            end
         end
         ST_OUT: begin
            rsp_valid = 1'b1;
            if (!rsp_stall) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= ST_CLEAR;
         clr_idx_ff <= '0;
         issue_ff   <= '0;
         v1_ff      <= 1'b0;
         v2_ff      <= 1'b0;
      end else begin
         state_ff   <= state_in;
         clr_idx_ff <= clr_idx_in;
         issue_ff   <= issue_in;
         v1_ff      <= v1_in;
         v2_ff      <= v2_in;
      end
   end

   always_ff @(posedge clock) begin
      px_ff    <= px_in;
      py_ff    <= py_in;
      taddr_ff <= taddr_in;
      tcode_ff <= tcode_in;
      tcol_ff  <= tcol_in;
      tpix_ff  <= tpix_in;
      color_ff <= color_in;
      dx1_ff   <= dx1_in;
      col1_ff  <= col1_in;
   end

   // The answer is the palette color with its two bytes swapped.
   assign rsp_pixel_color = {color_ff[7:0], color_ff[15:8]};

   tmspc_ram #(.AW(11), .DW(8)) u_vram (
      .clock (clock),
      .we    (vram_we),
      .waddr (vram_waddr),
      .wdata (vram_wdata),
      .raddr (vram_raddr),
      .rdata (vram_rdata)
   );

   tmspc_ram #(.AW(11), .DW(16)) u_tgfx (
      .clock (clock),
      .we    (tgfx_we),
      .waddr (req_address[10:0]),
      .wdata (req_data[15:0]),
      .raddr (tgfx_raddr),
      .rdata (tgfx_rdata)
   );

   tmspc_ram #(.AW(12), .DW(32)) u_sgfx (
      .clock (clock),
      .we    (sgfx_we),
      .waddr (req_address[11:0]),
      .wdata (req_data),
      .raddr (sgfx_raddr),
      .rdata (sgfx_rdata)
   );

   tmspc_ram #(.AW(8), .DW(16)) u_pal (
      .clock (clock),
      .we    (pal_we),
      .waddr (req_address[7:0]),
      .wdata (req_data[15:0]),
      .raddr (pal_raddr),
      .rdata (pal_rdata)
   );

   tmspc_sprite_list #(
      .SCREEN_WIDTH  (SCREEN_WIDTH),
      .SCREEN_HEIGHT (SCREEN_HEIGHT),
      .SPRITE_SLOTS  (SPRITE_SLOTS),
      .CNT_W         (CNT_W),
      .IDX_W         (IDX_W)
   ) u_sprites (
      .clock     (clock),
      .reset     (reset),
      .byte_we   (spr_we),
      .byte_idx  (spr_idx),
      .byte_data (req_data[7:0]),
      .latch     (latch),
      .rd_idx    (issue_ff[IDX_W-1:0]),
      .rd_entry  (entry),
      .count     (spr_count)
   );

endmodule

// ===== design/tmspc_ram.sv =====
// Simple dual-port synchronous RAM: one write port, one registered read port.
// No dependencies.
module tmspc_ram #(
   parameter int AW = 11,
   parameter int DW = 8
) (
   input  logic          clock,
   input  logic          we,
   input  logic [AW-1:0] waddr,
   input  logic [DW-1:0] wdata,
   input  logic [AW-1:0] raddr,
   output logic [DW-1:0] rdata
);

   logic [DW-1:0] mem [2**AW];
   logic [DW-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      rdata_ff <= mem[raddr];
   end

   assign rdata = rdata_ff;

endmodule

// ===== design/tmspc_sprite_list.sv =====
// Sprite attribute and position bytes and the latched sprite list.
// Depends on tmspc_pkg.
module tmspc_sprite_list
   import tmspc_pkg::*;
#(
   parameter int SCREEN_WIDTH  = 224,
   parameter int SCREEN_HEIGHT = 288,
   parameter int SPRITE_SLOTS  = 8,
   parameter int CNT_W         = 4,
   parameter int IDX_W         = 3
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             byte_we,
   input  logic [4:0]       byte_idx,
   input  logic [7:0]       byte_data,
   input  logic             latch,
   input  logic [IDX_W-1:0] rd_idx,
   output sprite_entry_type rd_entry,
   output logic [CNT_W-1:0] count
);

   localparam logic signed [9:0] SW = 10'(SCREEN_WIDTH);
   localparam logic signed [9:0] SH = 10'(SCREEN_HEIGHT);

   logic [7:0]       regs_ff [32];
   sprite_entry_type list_ff [SPRITE_SLOTS];
   sprite_entry_type list_in [SPRITE_SLOTS];
   logic [CNT_W-1:0] count_ff;
   logic [CNT_W-1:0] count_in;

   // Slots are scanned from the highest down; kept slots pack into the list.
   always_comb begin
      logic signed [9:0] x;
      logic signed [9:0] y;
      logic [CNT_W-1:0]  n;
      sprite_entry_type  e;
      list_in = list_ff;
      n = '0;
      for (int k = 7; k >= 0; k--) begin
         x = SPR_X_ORIGIN - signed'({2'b00, regs_ff[16 + 2*k]});
         y = SPR_Y_ORIGIN - signed'({2'b00, regs_ff[17 + 2*k]});
         e.x = x;
         e.y = y;
         e.code = regs_ff[2*k][7:2];
         e.flip = regs_ff[2*k][1:0];
         e.color = regs_ff[2*k + 1][5:0];
         if (x > SPR_MIN_POS && x < SW && y > SPR_MIN_POS && y < SH
             && n < CNT_W'(SPRITE_SLOTS)) begin
            for (int j = 0; j < SPRITE_SLOTS; j++) begin
               if (n == CNT_W'(j)) begin
                  list_in[j] = e;
               end
            end
            n = n + 1'b1;
         end
      end
      count_in = n;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < 32; i++) begin
            regs_ff[i] <= '0;
         end
         count_ff <= '0;
      end else begin
         if (byte_we) begin
            regs_ff[byte_idx] <= byte_data;
         end
         if (latch) begin
            count_ff <= count_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (latch) begin
         list_ff <= list_in;
      end
   end

   assign rd_entry = list_ff[rd_idx];
   assign count    = count_ff;

endmodule
